/* rtl/core/vfst_pkg.sv */
package vfst_pkg;

    localparam int TIME_W      = 48;
    localparam int TICK_W      = 36;
    localparam int TICK_FRAC_W = 16;
    localparam int TS_W        = 33;
    localparam int REP_W       = 2;
    localparam int SYNC_W      = 20;
    localparam int NOSYNC_W    = 27;
    localparam int DELAY_W     = 21;
    localparam int MS_W        = 16;
    localparam int FRAC_W      = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 48;

    localparam int HI_W    = TS_W + TICK_W - TICK_FRAC_W;
    localparam int LO_W    = TS_W + TICK_FRAC_W;
    localparam int SUM_W   = HI_W + 1;
    localparam int STEP_W  = TICK_W + 3;
    localparam int FSUM_W  = STEP_W + 1;
    localparam int QUO_W   = 23;
    localparam int RECIP_W = 31;
    localparam int RECIP_SHIFT = 37;
    localparam int PROD_W  = QUO_W + RECIP_W;

    localparam logic [CFG_IDX_W-1:0] REG_TICK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOSYNC = 2'd3;

    localparam logic [TICK_W-1:0]   TICK_RESET   = 36'd2621440000;
    localparam logic [SYNC_W-1:0]   SYNC_RESET   = 20'd10000;
    localparam logic [NOSYNC_W-1:0] NOSYNC_RESET = 27'd10000000;
    localparam logic [DELAY_W-1:0]  DELAY_RESET  = 21'd40000;

    localparam logic [LO_W-1:0]    ROUND_Q16     = LO_W'(32768);
    localparam logic [TIME_W-1:0]  ONE_SECOND_US = TIME_W'(1000000);
    localparam logic [TIME_W-1:0]  MIN_SHOW_US   = TIME_W'(10000);
    localparam logic [TIME_W-1:0]  ROUND_MS_US   = TIME_W'(500);
    localparam logic [TIME_W-1:0]  SAT_SHOW_US   = TIME_W'(65535500);
    localparam logic [MS_W-1:0]    MS_MAX        = 16'hFFFF;
    localparam logic [RECIP_W-1:0] RECIP_125     = 31'd1099511628;

    typedef struct packed {
        logic [TICK_W-1:0]   tick;
        logic [SYNC_W-1:0]   sync_thr;
        logic [NOSYNC_W-1:0] nosync_thr;
    } vfst_cfg_t;

    typedef struct packed {
        logic              load;
        logic [TIME_W-1:0] value;
    } vfst_load_t;

    typedef struct packed {
        logic              has_ts;
        logic [TS_W-1:0]   ticks;
        logic [REP_W-1:0]  rep;
        logic [TIME_W-1:0] ref_us;
        logic [TIME_W-1:0] now_us;
    } vfst_in_t;

    typedef struct packed {
        logic [TIME_W-1:0] pts;
        logic [TIME_W-1:0] ref_us;
        logic [TIME_W-1:0] now_us;
    } vfst_pts_t;

    typedef struct packed {
        logic [TIME_W-1:0]  pts;
        logic [DELAY_W-1:0] delay;
        logic [TIME_W-1:0]  target;
        logic [TIME_W-1:0]  now_us;
    } vfst_tgt_t;

    typedef struct packed {
        logic [TIME_W-1:0]  pts;
        logic [DELAY_W-1:0] delay;
        logic [MS_W-1:0]    show_ms;
    } vfst_out_t;

endpackage

/* rtl/core/vfst_pts.sv */
module vfst_pts import vfst_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  vfst_cfg_t cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  vfst_in_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output vfst_pts_t out_item
);

    logic              s1_valid_reg;
    vfst_in_t          s1_reg;
    logic              s2_valid_reg;
    logic              s2_has_ts_reg;
    logic [HI_W-1:0]   s2_prod_hi_reg;
    logic [LO_W-1:0]   s2_prod_lo_reg;
    logic [TIME_W-1:0] s2_clock_reg;
    logic [TIME_W-1:0] s2_ref_reg;
    logic [TIME_W-1:0] s2_now_reg;
    logic [TIME_W-1:0] clock_reg;
    logic [TIME_W-1:0] clock_next;
    logic [FRAC_W-1:0] frac_reg;
    logic [FRAC_W-1:0] frac_next;

    logic              s1_ready;
    logic              s2_ready;
    logic              s1_move;
    logic [STEP_W-1:0] step;
    logic [FSUM_W-1:0] frac_sum;
    logic [HI_W-1:0]   prod_hi;
    logic [LO_W-1:0]   prod_lo;
    logic [LO_W-1:0]   lo_round;
    logic [SUM_W-1:0]  scaled;
    logic [TIME_W-1:0] scaled_sat;
    logic [TIME_W-1:0] ts_pts;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;
    assign s1_move  = s1_valid_reg && s2_ready;

    assign prod_hi = HI_W'(s1_reg.ticks) * HI_W'(cfg.tick[TICK_W-1:TICK_FRAC_W]);
    assign prod_lo = LO_W'(s1_reg.ticks) * LO_W'(cfg.tick[TICK_FRAC_W-1:0]);

    // The clock advances by tick * (2 + repeats) in units of half a tick.
    assign step       = STEP_W'(cfg.tick) * STEP_W'({1'b0, s1_reg.rep} + 3'd2);
    assign frac_sum   = FSUM_W'(frac_reg) + FSUM_W'(step);
    assign clock_next = clock_reg + TIME_W'(frac_sum[FSUM_W-1:FRAC_W]);
    assign frac_next  = frac_sum[FRAC_W-1:0];

    assign lo_round   = s2_prod_lo_reg + ROUND_Q16;
    assign scaled     = SUM_W'(s2_prod_hi_reg) + SUM_W'(lo_round[LO_W-1:TICK_FRAC_W]);
    assign scaled_sat = (|scaled[SUM_W-1:TIME_W]) ? {TIME_W{1'b1}} : scaled[TIME_W-1:0];
    assign ts_pts     = s2_has_ts_reg ? scaled_sat : '0;

    assign out_valid       = s2_valid_reg;
    assign out_item.pts    = (ts_pts == '0) ? s2_clock_reg : ts_pts;
    assign out_item.ref_us = s2_ref_reg;
    assign out_item.now_us = s2_now_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            clock_reg    <= '0;
            frac_reg     <= '0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s1_move) begin
                clock_reg <= clock_next;
                frac_reg  <= frac_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_reg <= in_item;
        end
        if (s1_move) begin
            s2_has_ts_reg  <= s1_reg.has_ts;
            s2_prod_hi_reg <= prod_hi;
            s2_prod_lo_reg <= prod_lo;
            s2_clock_reg   <= clock_next;
            s2_ref_reg     <= s1_reg.ref_us;
            s2_now_reg     <= s1_reg.now_us;
        end
    end

endmodule

/* rtl/core/vfst_delay.sv */
module vfst_delay import vfst_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  vfst_cfg_t  cfg,
    input  vfst_load_t target_load,
    input  logic       in_valid,
    output logic       in_ready,
    input  vfst_pts_t  in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output vfst_tgt_t  out_item
);

    logic               s3_valid_reg;
    vfst_pts_t          s3_reg;
    logic               s4_valid_reg;
    logic [TIME_W-1:0]  s4_pts_reg;
    logic [DELAY_W-1:0] s4_delay_reg;
    logic [TIME_W-1:0]  s4_mag_reg;
    logic               s4_behind_reg;
    logic [TIME_W-1:0]  s4_now_reg;
    logic [TIME_W-1:0]  last_pts_reg;
    logic [DELAY_W-1:0] last_delay_reg;
    logic [DELAY_W-1:0] delay_next;
    logic [TIME_W-1:0]  target_reg;
    logic [TIME_W-1:0]  target_next;

    logic               s3_ready;
    logic               s4_ready;
    logic               s3_move;
    logic               s4_move;
    logic [TIME_W-1:0]  pts_diff;
    logic               diff_good;
    logic               behind;
    logic [TIME_W-1:0]  mag;
    logic [DELAY_W-1:0] sync_min;
    logic               correct;
    logic [DELAY_W-1:0] delay_final;

    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign in_ready = s3_ready;
    assign s3_move  = s3_valid_reg && s4_ready;
    assign s4_move  = s4_valid_reg && out_ready;

    assign pts_diff   = s3_reg.pts - last_pts_reg;
    assign diff_good  = (s3_reg.pts > last_pts_reg) && (pts_diff < ONE_SECOND_US);
    assign delay_next = diff_good ? pts_diff[DELAY_W-1:0] : last_delay_reg;
    assign behind     = s3_reg.pts <= s3_reg.ref_us;
    assign mag        = behind ? s3_reg.ref_us - s3_reg.pts : s3_reg.pts - s3_reg.ref_us;

    // A frame that is late by the threshold is shown at once; an early one waits twice.
    assign sync_min = (s4_delay_reg > DELAY_W'(cfg.sync_thr)) ? s4_delay_reg
                                                               : DELAY_W'(cfg.sync_thr);
    assign correct  = (s4_mag_reg < TIME_W'(cfg.nosync_thr)) &&
                      (s4_mag_reg >= TIME_W'(sync_min));
    assign delay_final = !correct      ? s4_delay_reg :
                         s4_behind_reg ? '0 : {s4_delay_reg[DELAY_W-2:0], 1'b0};
    assign target_next = target_reg + TIME_W'(delay_final);

    assign out_valid       = s4_valid_reg;
    assign out_item.pts    = s4_pts_reg;
    assign out_item.delay  = delay_final;
    assign out_item.target = target_next;
    assign out_item.now_us = s4_now_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            last_pts_reg   <= '0;
            last_delay_reg <= DELAY_RESET;
            target_reg     <= '0;
        end else begin
            if (s3_ready) begin
                s3_valid_reg <= in_valid;
            end
            if (s4_ready) begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (s3_move) begin
                last_pts_reg   <= s3_reg.pts;
                last_delay_reg <= delay_next;
            end
            if (target_load.load) begin
                target_reg <= target_load.value;
            end else if (s4_move) begin
                target_reg <= target_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_ready && in_valid) begin
            s3_reg <= in_item;
        end
        if (s3_move) begin
            s4_pts_reg    <= s3_reg.pts;
            s4_delay_reg  <= delay_next;
            s4_mag_reg    <= mag;
            s4_behind_reg <= behind;
            s4_now_reg    <= s3_reg.now_us;
        end
    end

endmodule

/* rtl/core/vfst_show.sv */
module vfst_show import vfst_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  vfst_tgt_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output vfst_out_t out_item
);

    logic               s5_valid_reg;
    vfst_tgt_t          s5_reg;
    logic               s6_valid_reg;
    logic [TIME_W-1:0]  s6_pts_reg;
    logic [DELAY_W-1:0] s6_delay_reg;
    logic [QUO_W-1:0]   s6_quo_reg;
    logic               s6_sat_reg;
    logic               s7_valid_reg;
    vfst_out_t          s7_reg;

    logic               s5_ready;
    logic               s6_ready;
    logic               s7_ready;
    logic               s5_move;
    logic               s6_move;
    logic [TIME_W-1:0]  gap;
    logic [TIME_W-1:0]  show_us;
    logic [TIME_W-1:0]  rounded;
    logic               sat;
    logic [PROD_W-1:0]  prod;
    logic [MS_W-1:0]    ms_next;

    assign s7_ready = !s7_valid_reg || out_ready;
    assign s6_ready = !s6_valid_reg || s7_ready;
    assign s5_ready = !s5_valid_reg || s6_ready;
    assign in_ready = s5_ready;
    assign s5_move  = s5_valid_reg && s6_ready;
    assign s6_move  = s6_valid_reg && s7_ready;

    assign gap     = (s5_reg.target > s5_reg.now_us) ? s5_reg.target - s5_reg.now_us : '0;
    assign show_us = (gap < MIN_SHOW_US) ? MIN_SHOW_US : gap;
    assign sat     = show_us >= SAT_SHOW_US;
    assign rounded = show_us + ROUND_MS_US;

    // Division by 1000 is a shift by three and a multiply by the reciprocal of 125.
    assign prod    = PROD_W'(s6_quo_reg) * PROD_W'(RECIP_125);
    assign ms_next = s6_sat_reg ? MS_MAX : prod[RECIP_SHIFT+MS_W-1:RECIP_SHIFT];

    assign out_valid = s7_valid_reg;
    assign out_item  = s7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end else begin
            if (s5_ready) begin
                s5_valid_reg <= in_valid;
            end
            if (s6_ready) begin
                s6_valid_reg <= s5_valid_reg;
            end
            if (s7_ready) begin
                s7_valid_reg <= s6_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s5_ready && in_valid) begin
            s5_reg <= in_item;
        end
        if (s5_move) begin
            s6_pts_reg   <= s5_reg.pts;
            s6_delay_reg <= s5_reg.delay;
            s6_quo_reg   <= rounded[QUO_W+2:3];
            s6_sat_reg   <= sat;
        end
        if (s6_move) begin
            s7_reg.pts     <= s6_pts_reg;
            s7_reg.delay   <= s6_delay_reg;
            s7_reg.show_ms <= ms_next;
        end
    end

endmodule

/* rtl/core/video_frame_sync_timer.sv */
// Paces decoded video frames against a reference clock.
// Each word on the s_ channel is one frame: s_tuser carries the has-timestamp flag and
// s_tdata the timestamp in codec ticks, the repeat count, the reference time and the
// current time. Each frame gives exactly one word on the m_ channel with the chosen
// presentation time, the corrected frame delay and the display delay in milliseconds.
// The cfg channel writes the tick, the start time (which loads the target
// timer), the sync threshold and the no-sync threshold; it is always ready, and it
// should be written only while no frame is in flight.
// The datapath is a seven-register pipeline, and one frame can be accepted every
// cycle while the receiver takes results. The running clock, the previous timestamp
// and delay, and the target timer each close their loop in a single stage, so
// back-to-back frames never wait on one another.
// When the receiver stalls, results hold in the output register and the pipeline
// keeps taking frames until every stage is full; s_tready then falls.
// Reset empties the pipeline, restores the register defaults, clears the running
// clock, the previous timestamp and the target timer, and sets the previous delay
// to 40 ms.
module video_frame_sync_timer import vfst_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // has_timestamp
    input  logic                  s_tuser,
    // timestamp_ticks, repeat_count, reference_us, now_us
    input  logic [135:0]          s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // frame_pts_us, sync_delay_us, show_delay_ms
    output logic [87:0]           m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [TICK_W-1:0]   tick_reg;
    logic [SYNC_W-1:0]   sync_reg;
    logic [NOSYNC_W-1:0] nosync_reg;

    vfst_cfg_t  cfg;
    vfst_load_t target_load;
    vfst_in_t   in_item;
    logic       pts_valid;
    logic       pts_ready;
    vfst_pts_t  pts_item;
    logic       tgt_valid;
    logic       tgt_ready;
    vfst_tgt_t  tgt_item;
    vfst_out_t  out_item;
    logic       cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign cfg.tick       = tick_reg;
    assign cfg.sync_thr   = sync_reg;
    assign cfg.nosync_thr = nosync_reg;

    assign target_load.load  = cfg_write && (cfg_index == REG_START);
    assign target_load.value = cfg_data[TIME_W-1:0];

    assign in_item.has_ts = s_tuser;
    assign in_item.ticks  = s_tdata[32:0];
    assign in_item.rep    = s_tdata[34:33];
    assign in_item.ref_us = s_tdata[82:35];
    assign in_item.now_us = s_tdata[130:83];

    assign m_tdata = {3'b000, out_item.show_ms, out_item.delay, out_item.pts};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg   <= TICK_RESET;
            sync_reg   <= SYNC_RESET;
            nosync_reg <= NOSYNC_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_TICK:   tick_reg   <= cfg_data[TICK_W-1:0];
                REG_SYNC:   sync_reg   <= cfg_data[SYNC_W-1:0];
                REG_NOSYNC: nosync_reg <= cfg_data[NOSYNC_W-1:0];
                default: ;
            endcase
        end
    end

    vfst_pts u_pts (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (pts_valid),
        .out_ready (pts_ready),
        .out_item  (pts_item)
    );

    vfst_delay u_delay (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .target_load (target_load),
        .in_valid    (pts_valid),
        .in_ready    (pts_ready),
        .in_item     (pts_item),
        .out_valid   (tgt_valid),
        .out_ready   (tgt_ready),
        .out_item    (tgt_item)
    );

    vfst_show u_show (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (tgt_valid),
        .in_ready  (tgt_ready),
        .in_item   (tgt_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

endmodule
